// ===== design/bfdh_pkg.sv =====
// ============================================================================
// Bloom filter double-hash package
// Shared types, codes and helper functions for the Bloom filter engine.
// ============================================================================
`default_nettype none

package bfdh_pkg;

    localparam int KEY_W       = 64;
    localparam int HALF_W      = 32;
    localparam int FBYTES_W    = 13;
    localparam int PROBE_W     = 6;
    localparam int BITS_W      = FBYTES_W + 3;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 13;
    localparam int DIV_RADIX   = 2;
    localparam int DIV_STEPS   = HALF_W / DIV_RADIX;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_BYTES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_COUNT  = 8'd1;

    localparam logic [FBYTES_W-1:0] FILTER_BYTES_RST = 13'd4096;
    localparam logic [PROBE_W-1:0]  PROBE_COUNT_RST  = 6'd7;

    typedef struct packed {
        logic [BITS_W-1:0]  bits;
        logic [PROBE_W-1:0] probes;
    } cfg_t;

    typedef struct packed {
        logic              opcode;
        logic              trivial;
        logic [KEY_W-1:0]  key;
    } cmd_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PROBE,
        S_RESULT
    } back_state_t;

    // One restoring step of a remainder: shift in one dividend bit and
    // subtract the divisor once if the partial remainder reaches it.
    function automatic logic [BITS_W-1:0] mod_step(
        input logic [BITS_W-1:0] rem,
        input logic              din,
        input logic [BITS_W-1:0] div
    );
        logic [BITS_W:0] t;
        t = {rem, din};
        if (t >= {1'b0, div})
        begin
            t = t - {1'b0, div};
        end
        return t[BITS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/bfdh_front.sv =====
// ============================================================================
// Bloom filter front stage
// Accepts key transactions, flags those that need no store access and hands
// them to the command queue.
// ============================================================================
`default_nettype none

module bfdh_front
    import bfdh_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire logic               clearing,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [KEY_W-1:0]   s_axis_tdata,   // key_hash
    input  wire logic               s_axis_tuser,   // opcode
    output logic                    push,
    output cmd_t                    push_cmd,
    input  wire logic               push_ready
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    logic accept;

    assign s_axis_tready = !clearing && (!valid_reg || push_ready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = valid_reg;
    assign push_cmd      = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.opcode  <= s_axis_tuser;
            cmd_reg.trivial <= (cfg.bits == '0) || (cfg.probes == '0);
            cmd_reg.key     <= s_axis_tdata;
        end
    end

endmodule

`default_nettype wire

// ===== design/bfdh_queue.sv =====
// ============================================================================
// Bloom filter command queue
// A short first-in first-out buffer between the front and back stages.
// ============================================================================
`default_nettype none

module bfdh_queue
    import bfdh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      push_ready,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("command queue holds more entries than its depth");

endmodule

`default_nettype wire

// ===== design/bfdh_back.sv =====
// ============================================================================
// Bloom filter back stage
// Clears the bit store after reset, reduces key hashes by the size in use
// and walks their probe positions, then presents one result per command.
// ============================================================================
`default_nettype none

module bfdh_back
    import bfdh_pkg::*;
#(
    parameter int MAX_FILTER_BYTES = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    output logic             clearing,
    input  wire logic        pop_valid,
    input  wire cmd_t        pop_cmd,
    output logic             pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // maybe_present, then zero fill
    output logic             m_axis_tuser    // was_query
);

    localparam int DEPTH  = MAX_FILTER_BYTES * 8;
    localparam int ADDR_W = $clog2(DEPTH);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic                 op_reg;
    logic                 op_next;
    logic                 present_reg;
    logic                 present_next;
    logic [HALF_W-1:0]    lo_reg;
    logic [HALF_W-1:0]    lo_next;
    logic [HALF_W-1:0]    hi_reg;
    logic [HALF_W-1:0]    hi_next;
    logic [BITS_W-1:0]    rlo_reg;
    logic [BITS_W-1:0]    rlo_next;
    logic [BITS_W-1:0]    rhi_reg;
    logic [BITS_W-1:0]    rhi_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;
    logic [BITS_W-1:0]    pos_reg;
    logic [BITS_W-1:0]    pos_next;
    logic [BITS_W-1:0]    step_reg;
    logic [BITS_W-1:0]    step_next;
    logic [PROBE_W-1:0]   cnt_reg;
    logic [PROBE_W-1:0]   cnt_next;
    logic                 pend_reg;
    logic                 pend_next;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [ADDR_W-1:0]    clr_addr_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_query_reg;
    logic                 out_query_next;
    logic                 out_present_reg;
    logic                 out_present_next;

    logic                 store_mem [DEPTH];
    logic                 rdata_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic                 mem_wdata;
    logic [ADDR_W-1:0]    mem_addr;

    logic [BITS_W-1:0]    lo_r1;
    logic [BITS_W-1:0]    lo_r2;
    logic [BITS_W-1:0]    hi_r1;
    logic [BITS_W-1:0]    hi_r2;
    logic [BITS_W:0]      pos_sum;
    logic [BITS_W:0]      pos_wrap;
    logic                 miss;
    logic                 issue;

    assign clearing      = (state_reg == S_CLEAR);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_query_reg;
    assign m_axis_tdata  = {7'd0, out_present_reg};

    assign lo_r1 = mod_step(rlo_reg, lo_reg[HALF_W-1], cfg.bits);
    assign lo_r2 = mod_step(lo_r1, lo_reg[HALF_W-2], cfg.bits);
    assign hi_r1 = mod_step(rhi_reg, hi_reg[HALF_W-1], cfg.bits);
    assign hi_r2 = mod_step(hi_r1, hi_reg[HALF_W-2], cfg.bits);

    assign pos_sum  = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_wrap = (pos_sum >= {1'b0, cfg.bits}) ? (pos_sum - {1'b0, cfg.bits}) : pos_sum;

    assign miss  = pend_reg && !rdata_reg && (op_reg == OP_QUERY);
    assign issue = (state_reg == S_PROBE) && (cnt_reg != cfg.probes) && !miss;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        present_next     = present_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        rlo_next         = rlo_reg;
        rhi_next         = rhi_reg;
        div_cnt_next     = div_cnt_reg;
        pos_next         = pos_reg;
        step_next        = step_reg;
        cnt_next         = cnt_reg;
        pend_next        = 1'b0;
        clr_addr_next    = clr_addr_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_query_next   = out_query_reg;
        out_present_next = out_present_reg;
        pop              = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_wdata        = 1'b0;
        mem_addr         = ADDR_W'(pos_reg);

        case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                pop = pop_valid;
                if (pop_valid)
                begin
                    op_next = pop_cmd.opcode;
                    if (pop_cmd.trivial)
                    begin
                        present_next = pop_cmd.opcode;
                        state_next   = S_RESULT;
                    end
                    else
                    begin
                        lo_next      = pop_cmd.key[HALF_W-1:0];
                        hi_next      = pop_cmd.key[KEY_W-1:HALF_W] | HALF_W'(1);
                        rlo_next     = '0;
                        rhi_next     = '0;
                        div_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                lo_next      = lo_reg << DIV_RADIX;
                hi_next      = hi_reg << DIV_RADIX;
                rlo_next     = lo_r2;
                rhi_next     = hi_r2;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    pos_next     = lo_r2;
                    step_next    = hi_r2;
                    cnt_next     = '0;
                    present_next = 1'b1;
                    state_next   = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (issue)
                begin
                    mem_we    = (op_reg == OP_INSERT);
                    mem_re    = (op_reg == OP_QUERY);
                    mem_wdata = 1'b1;
                    pend_next = (op_reg == OP_QUERY);
                    pos_next  = pos_wrap[BITS_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (miss)
                begin
                    present_next = 1'b0;
                    state_next   = S_RESULT;
                end
                else if ((cnt_reg == cfg.probes) && !pend_reg)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_query_next   = op_reg;
                    out_present_next = (op_reg == OP_QUERY) && present_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        present_reg     <= present_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        rlo_reg         <= rlo_next;
        rhi_reg         <= rhi_next;
        div_cnt_reg     <= div_cnt_next;
        pos_reg         <= pos_next;
        step_reg        <= step_next;
        cnt_reg         <= cnt_next;
        out_query_reg   <= out_query_next;
        out_present_reg <= out_present_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_addr];
        end
    end

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !pop)
        else $error("command taken while the store is being cleared");

    a_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (cnt_reg <= cfg.probes))
        else $error("probe counter ran past the probe count");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (pos_reg < cfg.bits) && (step_reg < cfg.bits))
        else $error("probe position outside the size in use");

    a_pend_query: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (op_reg == OP_QUERY) && $past(state_reg == S_PROBE))
        else $error("store read pending outside a query walk");

endmodule

`default_nettype wire

// ===== design/bloom_filter_double_hash.sv =====
// ============================================================================
// Bloom filter double-hash engine
// Top level: configuration registers, front stage, command queue and back
// stage with the bit store.
// ============================================================================
// After reset the engine clears its bit store, one bit a cycle, and accepts
// no key transaction until that is done. Each key is then handled in turn by
// the back stage. It takes the key, then two remainder units reduce both hash
// halves by the size in use (two quotient bits a cycle each). The walk then
// makes one probe a cycle on the single bit-wide store port and closes, a
// query after checking its last read, and the result is presented. A query
// stops its walk at the first clear bit that it reads. A key with zero size
// or zero probes skips the reduction and the walk. The front stage and a
// two-entry queue keep taking keys while the back stage works.
`default_nettype none

module bloom_filter_double_hash
    import bfdh_pkg::*;
#(
    parameter int MAX_FILTER_BYTES = 4096,
    parameter int MAX_PROBES       = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [KEY_W-1:0]      s_axis_tdata,   // key_hash
    input  wire logic                  s_axis_tuser,   // opcode
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // maybe_present, zero fill
    output logic                       m_axis_tuser    // was_query
);

    logic [FBYTES_W-1:0] filter_bytes_reg;
    logic [PROBE_W-1:0]  probe_count_reg;
    logic [FBYTES_W-1:0] fbytes_sat;
    logic [PROBE_W-1:0]  probes_sat;
    cfg_t                cfg;
    logic                clearing;
    logic                push;
    cmd_t                push_cmd;
    logic                push_ready;
    logic                pop;
    logic                pop_valid;
    cmd_t                pop_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bytes_reg <= FILTER_BYTES_RST;
            probe_count_reg  <= PROBE_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FILTER_BYTES: filter_bytes_reg <= cfg_data[FBYTES_W-1:0];
                REG_PROBE_COUNT:  probe_count_reg  <= cfg_data[PROBE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign fbytes_sat = (32'(filter_bytes_reg) > MAX_FILTER_BYTES)
                      ? FBYTES_W'(MAX_FILTER_BYTES) : filter_bytes_reg;
    assign probes_sat = (32'(probe_count_reg) > MAX_PROBES)
                      ? PROBE_W'(MAX_PROBES) : probe_count_reg;
    assign cfg        = '{bits: {fbytes_sat, 3'b000}, probes: probes_sat};

    bfdh_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .clearing      (clearing),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_cmd      (push_cmd),
        .push_ready    (push_ready)
    );

    bfdh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    bfdh_back #(
        .MAX_FILTER_BYTES (MAX_FILTER_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .clearing      (clearing),
        .pop_valid     (pop_valid),
        .pop_cmd       (pop_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ============================================================================
// Bloom filter double-hash engine testbench
// Drives insert and query key transactions and register writes into the
// engine, predicts every answer from a bit-accurate copy of the bit store and
// compares each result transaction field by field with the oldest prediction.
// A short directed table covers reset, the field extremes and the saturating
// and degenerate settings. Random segments then run under ten register
// settings and four idling patterns on both stream sides.
// ============================================================================
`timescale 1ns / 100ps

module tb_top
    import bfdh_pkg::*;
();

    localparam int MAX_BYTES     = 4096;
    localparam int STORE_BITS    = MAX_BYTES * 8;
    localparam int PROBE_LIMIT   = 32;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int END_CYCLES    = 64;
    localparam int SEGMENT_ITEMS = 75;
    localparam int SEGMENTS      = 10;
    localparam int POOL_DEPTH    = 48;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd200;

    typedef enum logic [1:0] {CHK_MODEL, CHK_ABSENT, CHK_PRESENT} chk_t;
    typedef enum logic {ROW_KEY, ROW_REG} row_kind_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  op;
        logic [KEY_W-1:0]      key;
        chk_t                  chk;
    } row_t;

    typedef struct packed {
        logic was_query;
        logic maybe_present;
    } answer_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [KEY_W-1:0]      s_axis_tdata  = '0;   // key_hash
    logic                  s_axis_tuser  = 1'b0; // opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;         // maybe_present, zero fill
    logic                  m_axis_tuser;         // was_query

    bit                    filter_bits [STORE_BITS];
    logic [FBYTES_W-1:0]   model_fbytes = FILTER_BYTES_RST;
    logic [PROBE_W-1:0]    model_probes = PROBE_COUNT_RST;
    answer_t               expected_answers [$];
    logic [KEY_W-1:0]      key_pool [$];
    row_t                  directed_rows [$];

    int mismatches         = 0;
    int cycle_count        = 0;
    int keys_sent          = 0;
    int queries_seen       = 0;
    int present_seen       = 0;
    int settings_done      = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    bloom_filter_double_hash dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, expected_answers.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
        mismatches++;
    endtask

    // Walks the probe sequence of one key over the predicted store, setting
    // bits for an insert and testing them for a query.
    function automatic answer_t apply_key(logic op, logic [KEY_W-1:0] key);
        int unsigned nbits;
        int unsigned nprobes;
        int unsigned pos;
        int unsigned step;
        answer_t     ans;
        nbits   = (model_fbytes > MAX_BYTES) ? STORE_BITS : int'(model_fbytes) * 8;
        nprobes = (model_probes > PROBE_LIMIT) ? PROBE_LIMIT : int'(model_probes);
        ans.was_query     = (op == OP_QUERY);
        ans.maybe_present = (op == OP_QUERY);
        if (nbits != 0)
        begin
            pos  = key[HALF_W-1:0] % nbits;
            step = (key[KEY_W-1:HALF_W] | 32'd1) % nbits;
            for (int i = 0; i < nprobes; i++)
            begin
                if (op == OP_QUERY)
                begin
                    if (!filter_bits[pos])
                    begin
                        ans.maybe_present = 1'b0;
                        break;
                    end
                end
                else
                begin
                    filter_bits[pos] = 1'b1;
                end
                pos = pos + step;
                if (pos >= nbits)
                begin
                    pos = pos - nbits;
                end
            end
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_answers.size() == 0)
            begin
                report_mismatch("unexpected result", {m_axis_tuser, m_axis_tdata[6:0]}, 8'h00);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (m_axis_tuser !== want.was_query)
                begin
                    report_mismatch("was_query", {7'd0, m_axis_tuser},
                                    {7'd0, want.was_query});
                end
                if (m_axis_tdata[0] !== want.maybe_present)
                begin
                    report_mismatch("maybe_present", {7'd0, m_axis_tdata[0]},
                                    {7'd0, want.maybe_present});
                end
                if (m_axis_tdata[7:1] !== 7'd0)
                begin
                    report_mismatch("tdata fill", m_axis_tdata, {7'd0, want.maybe_present});
                end
                if (want.was_query)
                begin
                    queries_seen++;
                    if (want.maybe_present)
                    begin
                        present_seen++;
                    end
                end
            end
        end
    end

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                sender_idle_pct    = 75;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 75;
            end
            default:
            begin
                sender_idle_pct    = 16;
                receiver_stall_pct = 16;
            end
        endcase
    endtask

    task automatic send_key(logic op, logic [KEY_W-1:0] key, chk_t chk);
        answer_t ans;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        ans = apply_key(op, key);
        if (chk != CHK_MODEL)
        begin
            ans.maybe_present = (chk == CHK_PRESENT);
        end
        expected_answers = {expected_answers, ans};
        keys_sent++;
    endtask

    // Register writes only go in once every outstanding answer has arrived.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_answers.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_FILTER_BYTES)
        begin
            model_fbytes = data[FBYTES_W-1:0];
        end
        else if (idx == REG_PROBE_COUNT)
        begin
            model_probes = data[PROBE_W-1:0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [FBYTES_W-1:0]   seg_fbytes [SEGMENTS];
        logic [CFG_DATA_W-1:0] seg_probes [SEGMENTS];
        logic [KEY_W-1:0]      key;
        logic                  op;
        int                    r;

        seg_fbytes = '{13'd1, 13'd2, 13'd16, 13'd4096, 13'd0,
                       13'd3, 13'd8191, 13'd100, 13'd4095, 13'd8};
        seg_probes = '{13'd32, 13'd7, 13'd4, 13'd7, 13'd5,
                       13'd0, 13'd63, 13'd13, 13'd1, 13'h1fc7};

        directed_rows = '{
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_QUERY,  64'h0, CHK_ABSENT},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_QUERY,  64'hffff_ffff_ffff_ffff, CHK_ABSENT},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_INSERT, 64'h0, CHK_ABSENT},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_QUERY,  64'h0, CHK_MODEL},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_INSERT, 64'hffff_ffff_ffff_ffff, CHK_ABSENT},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_QUERY,  64'hffff_ffff_ffff_ffff, CHK_MODEL},
            '{ROW_REG, REG_PROBE_COUNT,  13'd32, OP_INSERT, 64'h0, CHK_MODEL},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_INSERT, 64'h8000_0000_0000_0001, CHK_ABSENT},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_QUERY,  64'h8000_0000_0000_0001, CHK_MODEL},
            '{ROW_REG, REG_PROBE_COUNT,  13'd63, OP_INSERT, 64'h0, CHK_MODEL},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_QUERY,  64'h0, CHK_MODEL},
            '{ROW_REG, REG_PROBE_COUNT,  13'd0, OP_INSERT, 64'h0, CHK_MODEL},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_QUERY,  64'h1234_5678_9abc_def0, CHK_PRESENT},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_INSERT, 64'h1234_5678_9abc_def0, CHK_ABSENT},
            '{ROW_REG, REG_FILTER_BYTES, 13'd0, OP_INSERT, 64'h0, CHK_MODEL},
            '{ROW_REG, REG_PROBE_COUNT,  13'd7, OP_INSERT, 64'h0, CHK_MODEL},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_QUERY,  64'h0fed_cba9_8765_4321, CHK_PRESENT},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_INSERT, 64'h0fed_cba9_8765_4321, CHK_ABSENT},
            '{ROW_REG, REG_FILTER_BYTES, 13'd8191, OP_INSERT, 64'h0, CHK_MODEL},
            '{ROW_REG, REG_PROBE_COUNT,  13'h0045, OP_INSERT, 64'h0, CHK_MODEL},
            '{ROW_REG, REG_UNMAPPED,     13'h1fff, OP_INSERT, 64'h0, CHK_MODEL},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_QUERY,  64'h0, CHK_MODEL},
            '{ROW_REG, REG_FILTER_BYTES, 13'd1, OP_INSERT, 64'h0, CHK_MODEL},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_INSERT, 64'h0000_0007_0000_0005, CHK_ABSENT},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_QUERY,  64'h0000_0007_0000_0005, CHK_MODEL},
            '{ROW_KEY, REG_FILTER_BYTES, 13'd0, OP_QUERY,  64'hdead_beef_0000_0003, CHK_MODEL}
        };

        set_idling(IDLE_NONE);
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                write_register(directed_rows[i].idx, directed_rows[i].data);
            end
            else
            begin
                send_key(directed_rows[i].op, directed_rows[i].key, directed_rows[i].chk);
            end
        end

        // Most random traffic inserts keys and queries them back so that the
        // full probe walk is exercised; the rest is unrelated or extreme keys.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            write_register(REG_FILTER_BYTES, seg_fbytes[seg]);
            write_register(REG_PROBE_COUNT, seg_probes[seg]);
            if (seg % 2 == 1)
            begin
                write_register(CFG_IDX_W'($urandom_range(255, int'(REG_PROBE_COUNT) + 1)),
                               CFG_DATA_W'($urandom));
            end
            settings_done++;
            key_pool.delete();
            set_idling(idle_mode_t'(seg % 4));
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                r = $urandom_range(99);
                if (r < 40 || key_pool.size() == 0)
                begin
                    op  = OP_INSERT;
                    key = {$urandom, $urandom};
                    key_pool = {key_pool, key};
                    if (key_pool.size() > POOL_DEPTH)
                    begin
                        void'(key_pool.pop_front());
                    end
                end
                else if (r < 75)
                begin
                    op  = OP_QUERY;
                    key = key_pool[$urandom_range(key_pool.size() - 1)];
                end
                else if (r < 92)
                begin
                    op  = OP_QUERY;
                    key = {$urandom, $urandom};
                end
                else
                begin
                    op = $urandom_range(1) ? OP_QUERY : OP_INSERT;
                    case ($urandom_range(3))
                        0:       key = '0;
                        1:       key = '1;
                        2:       key = {32'hffff_ffff, 32'($urandom)};
                        default: key = {32'($urandom), 32'h0};
                    endcase
                end
                send_key(op, key, CHK_MODEL);
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (END_CYCLES) @(posedge clk);

        $display("covered %0d key transactions under %0d random register settings",
                 keys_sent, settings_done);
        $display("and four idling patterns: %0d queries, %0d maybe-present, %0d mismatches",
                 queries_seen, present_seen, mismatches);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/bfdh_pkg.sv
design/bfdh_front.sv
design/bfdh_queue.sv
design/bfdh_back.sv
design/bloom_filter_double_hash.sv
tb/sv/tb_top.sv
